// File: rtl/core/dsc_pkg.sv
// Shared types and constants of the divisible substring counter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package dsc_pkg;

  // field and register widths
  localparam int DIGIT_W    = 4;
  localparam int TOTAL_W    = 40;
  localparam int CNT_W      = 21;
  localparam int MOD_CFG_W  = 14;
  localparam int LEN_CFG_W  = 21;
  localparam int CFG_DATA_W = 21;

  // histogram epoch tag and front-to-back queue depth (power of two)
  localparam int EPOCH_W     = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // configuration register indexes
  typedef enum logic {
    CFG_MODULUS = 1'b0,
    CFG_LENGTH  = 1'b1
  } cfg_idx_t;

  // how the back end treats an item
  typedef enum logic {
    MODE_RESIDUE   = 1'b0,
    MODE_LASTDIGIT = 1'b1
  } mode_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    mode_t              mode;
    logic               hit;
  } dsc_item_t;

endpackage

// File: rtl/core/dsc_front.sv
// Front end: accepts digit items and classifies them for the back end.
// Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_front import dsc_pkg::*; #(
  parameter int MAX_MODULUS = 16384
) (
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [3:0] digit
  input  logic                                 in_tlast,   // last
  input  logic [$clog2(MAX_MODULUS+1)-1:0]     m_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output dsc_item_t                            item_o
);

  localparam int MW = $clog2(MAX_MODULUS + 1);

  logic [DIGIT_W-1:0] digit;
  logic               is_two;
  logic               is_five;

  assign digit   = in_tdata[DIGIT_W-1:0];
  assign is_two  = (m_i == MW'(2));
  assign is_five = (m_i == MW'(5));

  // take an item whenever the queue has room
  assign in_tready = !full_i;
  assign push_o    = in_tvalid && !full_i;

  // moduli 2 and 5 only look at the last digit of each substring
  always_comb begin
    item_o.digit = digit;
    item_o.last  = in_tlast;
    item_o.mode  = (is_two || is_five) ? MODE_LASTDIGIT : MODE_RESIDUE;
    if (is_two) begin
      item_o.hit = !digit[0];
    end else begin
      item_o.hit = (digit == DIGIT_W'(0)) || (digit == DIGIT_W'(5));
    end
  end

endmodule

// File: rtl/core/dsc_queue.sv
// Short queue of classified items between front and back end.
// Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_queue import dsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_i,
  input  dsc_item_t push_item_i,
  output logic      full_o,
  output logic      valid_o,
  output dsc_item_t head_o,
  input  logic      pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dsc_item_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_r == CW'(QUEUE_DEPTH));
  assign valid_o = (count_r != '0);
  assign head_o  = slot_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item_i;
    end
  end

endmodule

// File: rtl/core/dsc_resid.sv
// Residue unit: new suffix residue and next power of ten, both mod m.
// Bit-serial reduction when needed, then a multiply over the digit bits by compare-subtract.
// Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_resid import dsc_pkg::*; #(
  parameter int MAX_MODULUS = 16384
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic [$clog2(MAX_MODULUS)-1:0]    s_i,
  input  logic [$clog2(MAX_MODULUS)-1:0]    p_i,
  input  logic [DIGIT_W-1:0]                digit_i,
  input  logic [$clog2(MAX_MODULUS+1)-1:0]  m_i,
  output logic                              done_o,
  output logic [$clog2(MAX_MODULUS)-1:0]    r_o,
  output logic [$clog2(MAX_MODULUS)-1:0]    p_next_o
);

  localparam int RW  = $clog2(MAX_MODULUS);
  localparam int BCW = (RW > 1) ? $clog2(RW) : 1;
  localparam int SW  = $clog2(DIGIT_W);
  localparam logic [DIGIT_W-1:0] TEN = DIGIT_W'(10);

  typedef enum logic [1:0] {
    R_IDLE,
    R_REDUCE,
    R_MUL,
    R_ADD
  } rstate_t;

  rstate_t            state_r, state_nxt;
  logic               done_r, done_nxt;
  logic [RW-1:0]      sh_s_r, sh_s_nxt;
  logic [RW-1:0]      sh_p_r, sh_p_nxt;
  logic [RW-1:0]      rem_s_r, rem_s_nxt;
  logic [RW-1:0]      rem_p_r, rem_p_nxt;
  logic [BCW-1:0]     bit_r, bit_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic [RW-1:0]      a_r, a_nxt;
  logic [RW-1:0]      b_r, b_nxt;
  logic [RW-1:0]      acc_d_r, acc_d_nxt;
  logic [RW-1:0]      acc_p_r, acc_p_nxt;
  logic [RW-1:0]      r_r, r_nxt;
  logic [RW-1:0]      pn_r, pn_nxt;
  logic [RW:0]        mx;
  logic [RW-1:0]      dbl_d, dbl_p;

  // one conditional subtract: x below 2m gives x mod m
  function automatic logic [RW-1:0] csub(input logic [RW:0] x, input logic [RW:0] m);
    logic [RW:0] d;
    d = (x >= m) ? x - m : x;
    return d[RW-1:0];
  endfunction

  assign mx       = (RW+1)'(m_i);
  assign done_o   = done_r;
  assign r_o      = r_r;
  assign p_next_o = pn_r;
  assign dbl_d    = csub({acc_d_r, 1'b0}, mx);
  assign dbl_p    = csub({acc_p_r, 1'b0}, mx);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    sh_s_nxt  = sh_s_r;
    sh_p_nxt  = sh_p_r;
    rem_s_nxt = rem_s_r;
    rem_p_nxt = rem_p_r;
    bit_nxt   = bit_r;
    step_nxt  = step_r;
    digit_nxt = digit_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_d_nxt = acc_d_r;
    acc_p_nxt = acc_p_r;
    r_nxt     = r_r;
    pn_nxt    = pn_r;
    unique case (state_r)
      R_IDLE: begin
        if (start_i) begin
          digit_nxt = digit_i;
          acc_d_nxt = '0;
          acc_p_nxt = '0;
          step_nxt  = SW'(DIGIT_W - 1);
          // stored residues are normally already below m
          if ((RW+1)'(s_i) < mx && (RW+1)'(p_i) < mx) begin
            a_nxt     = s_i;
            b_nxt     = p_i;
            state_nxt = R_MUL;
          end else begin
            sh_s_nxt  = s_i;
            sh_p_nxt  = p_i;
            rem_s_nxt = '0;
            rem_p_nxt = '0;
            bit_nxt   = BCW'(RW - 1);
            state_nxt = R_REDUCE;
          end
        end
      end
      R_REDUCE: begin
        // restoring remainder, one bit of s and p per cycle
        rem_s_nxt = csub({rem_s_r, sh_s_r[RW-1]}, mx);
        rem_p_nxt = csub({rem_p_r, sh_p_r[RW-1]}, mx);
        sh_s_nxt  = sh_s_r << 1;
        sh_p_nxt  = sh_p_r << 1;
        bit_nxt   = bit_r - BCW'(1);
        if (bit_r == '0) begin
          a_nxt     = rem_s_nxt;
          b_nxt     = rem_p_nxt;
          state_nxt = R_MUL;
        end
      end
      R_MUL: begin
        // Horner over digit bits: digit * b and ten * b, mod m
        acc_d_nxt = digit_r[step_r] ? csub({1'b0, dbl_d} + {1'b0, b_r}, mx) : dbl_d;
        acc_p_nxt = TEN[step_r] ? csub({1'b0, dbl_p} + {1'b0, b_r}, mx) : dbl_p;
        step_nxt  = step_r - SW'(1);
        if (step_r == '0) begin
          state_nxt = R_ADD;
        end
      end
      R_ADD: begin
        r_nxt     = csub({1'b0, a_r} + {1'b0, acc_d_r}, mx);
        pn_nxt    = acc_p_r;
        done_nxt  = 1'b1;
        state_nxt = R_IDLE;
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      sh_s_r  <= sh_s_nxt;
      sh_p_r  <= sh_p_nxt;
      rem_s_r <= rem_s_nxt;
      rem_p_r <= rem_p_nxt;
      bit_r   <= bit_nxt;
      step_r  <= step_nxt;
      digit_r <= digit_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      acc_d_r <= acc_d_nxt;
      acc_p_r <= acc_p_nxt;
      r_r     <= r_nxt;
      pn_r    <= pn_nxt;
    end
  end

endmodule

// File: rtl/core/dsc_back.sv
// Back end: residue histogram, running total and output register.
// Uses the residue unit through its start/done ports. Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_back import dsc_pkg::*; #(
  parameter int MAX_MODULUS = 16384,
  parameter int MAX_LENGTH  = 1048576
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid_i,
  input  dsc_item_t                         q_item_i,
  output logic                              q_pop_o,
  input  logic [$clog2(MAX_LENGTH+1)-1:0]   len_i,
  output logic                              rs_start_o,
  output logic [$clog2(MAX_MODULUS)-1:0]    rs_s_o,
  output logic [$clog2(MAX_MODULUS)-1:0]    rs_p_o,
  output logic [DIGIT_W-1:0]                rs_digit_o,
  input  logic                              rs_done_i,
  input  logic [$clog2(MAX_MODULUS)-1:0]    rs_r_i,
  input  logic [$clog2(MAX_MODULUS)-1:0]    rs_p_next_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [TOTAL_W-1:0]                out_total_o,
  output logic                              out_last_o
);

  localparam int RW      = $clog2(MAX_MODULUS);
  localparam int LW      = $clog2(MAX_LENGTH + 1);
  localparam int AW      = (LW > CNT_W + 1) ? LW : CNT_W + 1;
  localparam int ENTRY_W = EPOCH_W + CNT_W;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RESID,
    B_READ,
    B_FINISH
  } bstate_t;

  bstate_t              state_r, state_nxt;
  logic [RW-1:0]        clr_r, clr_nxt;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  dsc_item_t            item_r, item_nxt;
  logic [RW-1:0]        suffix_r, suffix_nxt;
  logic [RW-1:0]        power_r, power_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]        add_r, add_nxt;
  logic [RW-1:0]        res_r, res_nxt;
  logic [RW-1:0]        pnext_r, pnext_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [ENTRY_W-1:0]   hist_mem [MAX_MODULUS];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic                 mem_re;

  logic                 slot_free;
  logic [CNT_W-1:0]     cur_cnt;
  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   sat_total;
  logic                 in_range;

  assign slot_free   = !out_valid_r || out_ready_i;
  assign q_pop_o     = (state_r == B_IDLE) && q_valid_i;
  assign rs_start_o  = q_pop_o && (q_item_i.mode == MODE_RESIDUE);
  assign rs_s_o      = suffix_r;
  assign rs_p_o      = power_r;
  assign rs_digit_o  = q_item_i.digit;
  assign out_valid_o = out_valid_r;
  assign out_total_o = out_total_r;
  assign out_last_o  = out_last_r;

  // an entry from an earlier string reads as zero
  assign cur_cnt   = (rd_data_r[ENTRY_W-1:CNT_W] == epoch_r) ? rd_data_r[CNT_W-1:0] : '0;
  assign sum       = {1'b0, total_r} + (TOTAL_W+1)'(add_r);
  assign sat_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign in_range  = 32'(idx_r) < 32'(len_i);

  // histogram port use
  assign mem_re    = (state_r == B_RESID) && rs_done_i;
  assign mem_we    = (state_r == B_CLEAR) || (state_r == B_READ);
  assign mem_waddr = (state_r == B_CLEAR) ? clr_r : res_r;
  assign mem_wdata = (state_r == B_CLEAR) ? '0 :
                     {epoch_r, (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1)};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    epoch_nxt     = epoch_r;
    item_nxt      = item_r;
    suffix_nxt    = suffix_r;
    power_nxt     = power_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    add_nxt       = add_r;
    res_nxt       = res_r;
    pnext_nxt     = pnext_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      B_CLEAR: begin
        // sweep the histogram, one entry a cycle
        clr_nxt = clr_r + RW'(1);
        if (clr_r == RW'(MAX_MODULUS - 1)) begin
          clr_nxt   = '0;
          epoch_nxt = EPOCH_W'(1);
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          item_nxt = q_item_i;
          if (q_item_i.mode == MODE_LASTDIGIT) begin
            add_nxt   = (q_item_i.hit && in_range) ? AW'(32'(len_i) - 32'(idx_r)) : '0;
            state_nxt = B_FINISH;
          end else begin
            state_nxt = B_RESID;
          end
        end
      end
      B_RESID: begin
        if (rs_done_i) begin
          res_nxt   = rs_r_i;
          pnext_nxt = rs_p_next_i;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        // histogram count plus the suffix that is itself divisible
        add_nxt    = AW'(cur_cnt) + AW'(res_r == '0);
        suffix_nxt = res_r;
        power_nxt  = pnext_r;
        state_nxt  = B_FINISH;
      end
      B_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = sat_total;
          out_last_nxt  = item_r.last;
          total_nxt     = sat_total;
          idx_nxt       = (idx_r == CNT_MAX) ? idx_r : idx_r + CNT_W'(1);
          state_nxt     = B_IDLE;
          if (item_r.last) begin
            total_nxt  = '0;
            idx_nxt    = '0;
            suffix_nxt = '0;
            power_nxt  = RW'(1);
            if (epoch_r == '1) begin
              clr_nxt   = '0;
              state_nxt = B_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // state, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      epoch_r     <= EPOCH_W'(1);
      suffix_r    <= '0;
      power_r     <= RW'(1);
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      epoch_r     <= epoch_nxt;
      suffix_r    <= suffix_nxt;
      power_r     <= power_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      add_r       <= add_nxt;
      res_r       <= res_nxt;
      pnext_r     <= pnext_nxt;
      out_total_r <= out_total_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // residue histogram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= hist_mem[rs_r_i];
    end
  end

  // no item leaves the queue during a clearing sweep
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLEAR) |-> !q_pop_o)
    else $error("item popped during histogram clear");

  // the last digit of a string restarts the count
  a_string_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FINISH && slot_free && item_r.last) |=> (total_r == '0 && idx_r == '0))
    else $error("count not restarted after last digit");

  // epoch zero is reserved for cleared entries
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch tag reached zero");

  // a finished item always lands in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FINISH && slot_free) |=> out_valid_r)
    else $error("result lost on output register");

endmodule

// File: rtl/core/divisible_substring_counter_unit.sv
// Top level of the divisible substring counter: configuration registers
// and the front end, queue, residue unit and back end.
// Depends on dsc_pkg, dsc_front, dsc_queue, dsc_resid, dsc_back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | slave     | in_tvalid / in_tready | in_tdata[3:0] digit, in_tlast
//  out     | master    | out_tvalid/out_tready | out_tdata[39:0] total, out_tlast
//  cfg     | write     | cfg_we                | cfg_idx, cfg_wdata
//
// Moduli 2 and 5: an item passes the back end's dispatch and result states.
// Other moduli: the residue unit's four bit-serial multiply steps over the
// digit and the histogram read-modify-write set the pace, one item at a time; a stored
// residue not below the modulus (after a modulus change, or the power of one
// at the start of each string under modulus one) adds a bit-serial
// reduction over log2(MAX_MODULUS) bits.
// After reset, and after every 255th string, the histogram is cleared in a
// sweep over all MAX_MODULUS entries during which no item leaves the queue.
// The output register lets the next item start while a result is stalled.
`timescale 1ns / 1ps

module divisible_substring_counter_unit import dsc_pkg::*; #(
  parameter int MAX_MODULUS = 16384,
  parameter int MAX_LENGTH  = 1048576
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [3:0] digit, [7:4] zero
  input  logic                  in_tlast,    // last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TOTAL_W-1:0]    out_tdata,   // [39:0] running_total
  output logic                  out_tlast,   // is_final
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW = $clog2(MAX_MODULUS);
  localparam int MW = $clog2(MAX_MODULUS + 1);
  localparam int LW = $clog2(MAX_LENGTH + 1);

  logic [MOD_CFG_W-1:0] modulus_r;
  logic [LEN_CFG_W-1:0] length_r;
  logic [MW-1:0]        m_eff;
  logic [LW-1:0]        len_eff;

  logic                 q_full;
  logic                 q_push;
  dsc_item_t            q_in_item;
  logic                 q_valid;
  dsc_item_t            q_head;
  logic                 q_pop;

  logic                 rs_start;
  logic [RW-1:0]        rs_s;
  logic [RW-1:0]        rs_p;
  logic [DIGIT_W-1:0]   rs_digit;
  logic                 rs_done;
  logic [RW-1:0]        rs_r;
  logic [RW-1:0]        rs_p_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_CFG_W'(3);
      length_r  <= LEN_CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_idx == CFG_MODULUS) begin
        modulus_r <= cfg_wdata[MOD_CFG_W-1:0];
      end else begin
        length_r <= cfg_wdata[LEN_CFG_W-1:0];
      end
    end
  end

  // modulus zero acts as one; both settings clamp to their maxima
  always_comb begin
    if (modulus_r == '0) begin
      m_eff = MW'(1);
    end else if (32'(modulus_r) > MAX_MODULUS) begin
      m_eff = MW'(MAX_MODULUS);
    end else begin
      m_eff = MW'(modulus_r);
    end
    if (32'(length_r) > MAX_LENGTH) begin
      len_eff = LW'(MAX_LENGTH);
    end else begin
      len_eff = LW'(length_r);
    end
  end

  dsc_front #(
    .MAX_MODULUS (MAX_MODULUS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .m_i       (m_eff),
    .full_i    (q_full),
    .push_o    (q_push),
    .item_o    (q_in_item)
  );

  dsc_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  dsc_resid #(
    .MAX_MODULUS (MAX_MODULUS)
  ) u_resid (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (rs_start),
    .s_i      (rs_s),
    .p_i      (rs_p),
    .digit_i  (rs_digit),
    .m_i      (m_eff),
    .done_o   (rs_done),
    .r_o      (rs_r),
    .p_next_o (rs_p_next)
  );

  dsc_back #(
    .MAX_MODULUS (MAX_MODULUS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_item_i    (q_head),
    .q_pop_o     (q_pop),
    .len_i       (len_eff),
    .rs_start_o  (rs_start),
    .rs_s_o      (rs_s),
    .rs_p_o      (rs_p),
    .rs_digit_o  (rs_digit),
    .rs_done_i   (rs_done),
    .rs_r_i      (rs_r),
    .rs_p_next_i (rs_p_next),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_total_o (out_tdata),
    .out_last_o  (out_tlast)
  );

endmodule
